// ===== hdl/sha512_384_hash_engine_unit_macros.svh =====
// assertion helpers for the hash engine
`ifndef SHA512_384_HASH_ENGINE_UNIT_MACROS_SVH
`define SHA512_384_HASH_ENGINE_UNIT_MACROS_SVH

// property that holds when not in reset
`define SHA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// payload that must not move while a valid item is stalled
`define SHA_HOLD(label, clk, rst_n, vld, stl, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && stl) |=> $stable(sig)) else $error(msg);

`endif

// ===== hdl/sha_pkg.sv =====
package sha_pkg;

  localparam int unsigned BlockBytes = 128;
  localparam int unsigned PadSplit   = 112;
  localparam int unsigned Rounds     = 80;

  // item queued between the byte front end and the compression back end
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_ACCEPT,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_LEN,
    ST_EMIT
  } core_state_e;

  localparam logic [63:0] SEED512 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] SEED384 [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  localparam logic [63:0] ROUND_K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

endpackage

// ===== hdl/sha_ram.sv =====
module sha_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/sha_fifo.sv =====
module sha_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sha_pkg::item_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output sha_pkg::item_t  pop_data_o,
  output logic            empty_o
);
  import sha_pkg::*;

  item_t      slot_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = slot_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    if (!push_i && pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= push_data_i;
  end
endmodule

// ===== hdl/sha_core.sv =====
module sha_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            mode_i,
  input  logic            item_avail_i,
  input  sha_pkg::item_t  item_i,
  output logic            item_pop_o,
  output logic [63:0]     digest_word_o,
  output logic [2:0]      word_index_o,
  output logic            last_word_o,
  output logic            out_valid_o,
  input  logic            out_stall_i
);
  import sha_pkg::*;

  core_state_e state_q, state_d;

  logic [63:0] h_q [8];
  logic [63:0] v_q [8];
  logic [63:0] w_q [16];
  logic [63:0] buf_wdata;
  logic [63:0] buf_rdata;
  logic        buf_we;
  logic [3:0]  buf_waddr, buf_raddr;

  logic [6:0]  fill_q;
  logic [63:0] count_q;
  logic        seed_q;
  logic [6:0]  rnd_q;
  logic [3:0]  pad_q;       // word index while padding
  logic        second_q;    // length block still to go after this one
  logic        clr_q;       // zeroing sweep ahead of the length block
  logic [2:0]  emit_q;
  logic        ovld_q;
  logic [63:0] word_q;      // byte assembly word
  logic [63:0] dig_q;
  logic        pend_last_q;

  logic [63:0] w_cur, s0, s1, t1, t2;
  logic [63:0] wa, wb;
  logic [2:0]  words_m1;
  logic        out_free;
  logic [6:0]  fill_inc;
  logic [6:0]  pad_shift;

  // block buffer is 16 words of 64 bits
  sha_ram #(.Width(64), .Depth(16)) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  assign words_m1 = mode_i ? 3'd5 : 3'd7;
  assign out_free = !ovld_q || !out_stall_i;
  assign fill_inc = fill_q + 7'd1;
  // moves the collected bytes of a partial word to the top
  assign pad_shift = 7'd64 - {1'b0, fill_q[2:0], 3'b000};

  assign wa = w_q[1];
  assign wb = w_q[14];
  assign s0 = rotr(wa, 1) ^ rotr(wa, 8) ^ (wa >> 7);
  assign s1 = rotr(wb, 19) ^ rotr(wb, 61) ^ (wb >> 6);
  assign w_cur = (rnd_q < 7'd16) ? buf_rdata : (w_q[0] + s0 + w_q[9] + s1);
  assign t1 = v_q[7] + (rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41))
            + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[rnd_q] + w_cur;
  assign t2 = (rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39))
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (item_avail_i) state_d = seed_q ? ST_SEED : ST_ACCEPT;
      ST_SEED:   state_d = ST_ACCEPT;
      ST_ACCEPT: begin
        if (item_i.present && fill_inc == 7'd0) state_d = ST_LOAD;
        else if (item_i.last) state_d = ST_PAD;
        else state_d = ST_IDLE;
      end
      ST_LOAD:   state_d = ST_ROUND;
      ST_ROUND:  if (rnd_q == 7'(Rounds - 1)) state_d = ST_FOLD;
      ST_FOLD: begin
        if (second_q) state_d = ST_PAD;
        else if (pend_last_q) state_d = ST_PAD;
        else state_d = ST_IDLE;
      end
      ST_PAD:    if (pad_q == 4'd15) state_d = second_q ? ST_LOAD : ST_LEN;
      ST_LEN:    state_d = ST_LOAD;
      ST_EMIT:   if (out_free && emit_q == words_m1) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
    if (state_q == ST_FOLD && !second_q && pend_last_q && pad_q == 4'd15) state_d = ST_EMIT;
  end

  // outputs of the control
  always_comb begin
    item_pop_o = state_q == ST_ACCEPT;
    buf_we     = 1'b0;
    buf_waddr  = fill_q[6:3];
    buf_wdata  = word_q;
    buf_raddr  = (state_q == ST_ROUND) ? 4'(rnd_q + 7'd1) : 4'd0;
    case (state_q)
      ST_ACCEPT: begin
        buf_we    = item_i.present;
        buf_wdata = {word_q[55:0], item_i.data};
      end
      ST_PAD: begin
        buf_we    = 1'b1;
        buf_waddr = pad_q;
        buf_wdata = '0;
        if (!clr_q) begin
          if (pad_q == fill_q[6:3]) begin
            buf_wdata = word_q << pad_shift;
            for (int i = 0; i < 8; i++) begin
              if (3'(i) == fill_q[2:0]) buf_wdata[63-8*i -: 8] = 8'h80;
              if (3'(i) > fill_q[2:0]) buf_wdata[63-8*i -: 8] = 8'h00;
            end
          end else if (pad_q < fill_q[6:3]) begin
            buf_we = 1'b0;
          end
        end
        // high half of the bit length in the length block
        if (pad_q == 4'd14 && !second_q) buf_wdata = {61'd0, count_q[63:61]};
      end
      ST_LEN: begin
        buf_we    = 1'b1;
        buf_waddr = 4'd15;
        buf_wdata = {count_q[60:0], 3'b000};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      count_q     <= '0;
      seed_q      <= 1'b1;
      rnd_q       <= '0;
      pad_q       <= '0;
      second_q    <= 1'b0;
      clr_q       <= 1'b0;
      emit_q      <= '0;
      ovld_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_free) ovld_q <= 1'b0;
      case (state_q)
        ST_SEED: begin
          seed_q  <= 1'b0;
          fill_q  <= '0;
          count_q <= '0;
        end
        ST_ACCEPT: begin
          pend_last_q <= item_i.last;
          pad_q       <= '0;
          if (item_i.present) begin
            fill_q  <= fill_inc;
            count_q <= count_q + 64'd1;
          end
        end
        ST_LOAD:  rnd_q <= '0;
        ST_ROUND: rnd_q <= rnd_q + 7'd1;
        ST_FOLD: begin
          if (second_q) begin
            second_q <= 1'b0;
            pad_q    <= '0;
            clr_q    <= 1'b1;
          end
          if (!second_q && pad_q == 4'd15) pend_last_q <= 1'b0;
          emit_q <= '0;
        end
        ST_PAD: begin
          pad_q <= pad_q + 4'd1;
          if (pad_q == 4'd0 && !clr_q) second_q <= fill_q >= 7'(PadSplit);
        end
        ST_LEN: begin
          pad_q <= 4'd15;
          clr_q <= 1'b0;
        end
        ST_EMIT: if (out_free) begin
          ovld_q <= 1'b1;
          emit_q <= emit_q + 3'd1;
          if (emit_q == words_m1) begin
            seed_q  <= 1'b1;
            fill_q  <= '0;
            count_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_SEED: for (int i = 0; i < 8; i++) h_q[i] <= mode_i ? SEED384[i] : SEED512[i];
      ST_ACCEPT: begin
        if (item_i.present) word_q <= {word_q[55:0], item_i.data};
      end
      ST_PAD: if (pad_q == 4'd15 && second_q) word_q <= '0;
      ST_LOAD: for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      ST_ROUND: begin
        v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= w_cur;
      end
      ST_FOLD: for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      ST_EMIT: if (out_free) begin
        dig_q        <= h_q[emit_q];
        word_index_o <= emit_q;
        last_word_o  <= emit_q == words_m1;
      end
      default: ;
    endcase
  end

  assign digest_word_o = dig_q;
  assign out_valid_o   = ovld_q;
endmodule

// ===== hdl/sha512_384_hash_engine_unit.sv =====
// a byte item passes idle and accept, the first of a message also seed; a full block
// adds a compression; last item: a padding sweep of the 16 buffer words, a length write
// and a compression; 112 tail bytes or more first add a compression and a zeroing sweep;
// then one digest word per cycle unless stalled, 8 words for sha-512 and 6 for sha-384
// throughput is set by the single shared round unit, one round per cycle
// reset clears control, sets mode to sha-512 and arms seeding of the next message
module sha512_384_hash_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);
  import sha_pkg::*;

  logic   mode_q;
  logic   full, empty, pop;
  item_t  push_item, head;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign push_item   = '{data: data_byte_i, present: byte_present_i, last: last_item_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mode_q <= 1'b0;
    else if (cfg_valid_i) mode_q <= cfg_data_i;
  end

  sha_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !full),
    .push_data_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head),
    .empty_o     (empty)
  );

  sha_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_i        (mode_q),
    .item_avail_i  (!empty),
    .item_i        (head),
    .item_pop_o    (pop),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i)
  );
endmodule

// ===== hdl/sha_checker.sv =====
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);
`include "sha512_384_hash_engine_unit_macros.svh"

  `SHA_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_stall_i, digest_word_o,
    "stalled word moved")
  `SHA_ASSERT(a_idx_step, clk_i, rst_ni,
    (out_valid_o && !out_stall_i && !last_word_o) |=> (!out_valid_o || word_index_o != 3'd0),
    "index restarted mid digest")
  `SHA_ASSERT(a_last_idx, clk_i, rst_ni,
    (out_valid_o && last_word_o) |-> (word_index_o == 3'd5 || word_index_o == 3'd7),
    "bad last index")
  `SHA_ASSERT(a_stall_known, clk_i, rst_ni, in_valid_i |-> !$isunknown(in_stall_o),
    "input stall unknown")
endmodule

bind sha512_384_hash_engine_unit sha_checker u_sha_checker (.*);

// ===== bench/sha512_384_hash_engine_unit_checker.sv =====
module sha512_384_hash_engine_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          digests_o
);
  import sha_pkg::*;

  typedef struct packed {
    logic [63:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic        mode_q;
  logic [63:0] hash_q [8];
  logic [7:0]  block_q [128];
  logic [6:0]  fill_q;
  logic [63:0] byte_count_q;
  logic        seed_pending_q;
  digest_beat_t expected_words[$];

  function automatic logic [63:0] ror64(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  task automatic compress_block();
    logic [63:0] w [16];
    logic [63:0] v [8];
    logic [63:0] wt, t1, t2, a, b;
    for (int i = 0; i < 8; i++) v[i] = hash_q[i];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = '0;
        for (int i = 0; i < 8; i++) wt = (wt << 8) | 64'(block_q[t * 8 + i]);
      end else begin
        a = w[(t - 15) & 15];
        b = w[(t - 2) & 15];
        wt = w[t & 15] + (ror64(a, 1) ^ ror64(a, 8) ^ (a >> 7)) + w[(t - 7) & 15]
             + (ror64(b, 19) ^ ror64(b, 61) ^ (b >> 6));
      end
      w[t & 15] = wt;
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + wt;
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] = hash_q[i] + v[i];
  endtask

  task automatic absorb_item(logic [7:0] data, logic present, logic last);
    int n;
    int words;
    logic [63:0] bits;
    digest_beat_t beat;
    if (seed_pending_q) begin
      for (int i = 0; i < 8; i++) hash_q[i] = mode_q ? SEED384[i] : SEED512[i];
      fill_q = '0;
      byte_count_q = '0;
      seed_pending_q = 1'b0;
    end
    if (present) begin
      block_q[fill_q] = data;
      fill_q = fill_q + 7'd1;
      byte_count_q = byte_count_q + 64'd1;
      if (fill_q == 0) compress_block();
    end
    if (!last) return;
    n = fill_q;
    block_q[n] = 8'h80;
    for (int i = n + 1; i < 128; i++) block_q[i] = 8'h00;
    if (n >= PadSplit) begin
      compress_block();
      for (int i = 0; i < 128; i++) block_q[i] = 8'h00;
    end
    bits = byte_count_q << 3;
    for (int i = 0; i < 8; i++) begin
      block_q[112 + i] = 8'(byte_count_q >> 61 >> (56 - 8 * i));
      block_q[120 + i] = 8'(bits >> (56 - 8 * i));
    end
    compress_block();
    words = mode_q ? 6 : 8;
    for (int i = 0; i < words; i++) begin
      beat.word = hash_q[i];
      beat.index = 3'(i);
      beat.last = (i == words - 1);
      expected_words.push_back(beat);
    end
    fill_q = '0;
    byte_count_q = '0;
    seed_pending_q = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_beat_t want;
    if (!rst_ni) begin
      mode_q = 1'b0;
      fill_q = '0;
      byte_count_q = '0;
      seed_pending_q = 1'b1;
      for (int i = 0; i < 8; i++) hash_q[i] = SEED512[i];
      expected_words.delete();
      fail_count_o = 0;
      digests_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) mode_q = cfg_data_i;
      if (in_valid_i && !in_stall_i) absorb_item(data_byte_i, byte_present_i, last_item_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected digest word %h index %0d", digest_word_i, word_index_i);
        end else begin
          want = expected_words.pop_front();
          if (want.word !== digest_word_i || want.index !== word_index_i
              || want.last !== last_word_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: want %h/%0d/%b got %h/%0d/%b", want.word, want.index,
                       want.last, digest_word_i, word_index_i, last_word_i);
          end
          if (last_word_i) digests_o++;
        end
      end
      pending_o = expected_words.size();
    end
  end
endmodule

// ===== bench/tb_sha512_384_hash_engine_unit.sv =====
module tb_sha512_384_hash_engine_unit;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        byte_present = 1'b0;
  logic        last_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  int          fail_count, pending, digests;
  int          cycle_count = 0;
  int          item_count = 0;
  int          idle_pct = 27;
  bit          hold_off = 1'b0;

  always #5 clk = ~clk;

  sha512_384_hash_engine_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .data_byte_i(data_byte), .byte_present_i(byte_present), .last_item_i(last_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .digest_word_o(digest_word), .word_index_o(word_index), .last_word_o(last_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  sha512_384_hash_engine_unit_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .data_byte_i(data_byte), .byte_present_i(byte_present), .last_item_i(last_item),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .digest_word_i(digest_word), .word_index_i(word_index), .last_word_i(last_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .digests_o(digests)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("timeout with %0d words outstanding", pending);
      $display("tb_sha512_384_hash_engine_unit: done, errors");
      $finish;
    end
  end

  // receiver stalls at random, or solidly during a hold-off
  always @(posedge clk)
    out_stall <= hold_off || ($urandom_range(99) < idle_pct);

  task automatic send_item(logic [7:0] data, logic present, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= data;
    byte_present <= present;
    last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    item_count++;
  endtask

  task automatic send_message(int len, bit empty_tail, bit junk);
    for (int i = 0; i < len; i++) begin
      if (junk && $urandom_range(7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1) && !empty_tail);
    end
    if (empty_tail || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic write_mode(logic mode);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int len;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty message, extreme bytes, pad boundaries
    send_message(0, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    write_mode(1'b1);
    send_message(3, 1'b0, 1'b0);
    // mode flips mid message: seed stays sha-384, word count follows sha-512
    send_item(8'h61, 1'b1, 1'b0);
    write_mode(1'b0);
    send_item(8'h62, 1'b1, 1'b1);
    idle_pct = 0;
    send_message(112, 1'b0, 1'b0);
    send_message(128, 1'b0, 1'b0);
    send_message(127, 1'b1, 1'b0);
    // hold-off: receiver blocks while messages keep coming
    hold_off = 1'b1;
    fork
      begin repeat (400) @(posedge clk); hold_off = 1'b0; end
      begin send_message(2, 1'b0, 1'b0); send_message(1, 1'b0, 1'b0); end
    join
    idle_pct = 27;
    while (item_count < 420) begin
      if ($urandom_range(9) == 0) write_mode(1'($urandom));
      len = $urandom_range(20);
      send_message(len, $urandom_range(3) == 0, $urandom_range(3) == 0);
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("%0d items sent, %0d digests checked, both modes and padding split cases",
             item_count, digests);
    if (fail_count == 0)
      $display("tb_sha512_384_hash_engine_unit: done, clean");
    else
      $display("tb_sha512_384_hash_engine_unit: done, errors");
    $finish;
  end
endmodule
